// ----- sv/ccr_pkg.sv -----
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types, constants and table helpers for the colour contrast ratio
// pipeline.
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int unsigned LUM_W          = 17;
  localparam int unsigned SUM_W          = 30;
  localparam int unsigned RECIP_W        = 30;
  localparam int unsigned PROD_W         = SUM_W + RECIP_W;
  localparam int unsigned SCALED_W       = 21;
  localparam int unsigned RATIO_INT_BITS = 5;

  localparam logic [LUM_W-1:0] LUM_ONE = LUM_W'(65536);

  // Rec. 709 luma weights, scaled by 10000
  localparam int unsigned WEIGHT_R = 2126;
  localparam int unsigned WEIGHT_G = 7152;
  localparam int unsigned WEIGHT_B = 722;

  // floor(x / 10000) == (x * RECIP_10000) >> RECIP_SHIFT for x < 2**30
  localparam logic [RECIP_W-1:0] RECIP_10000 = RECIP_W'(879609303);
  localparam int unsigned        RECIP_SHIFT = 43;

  // 20 * (L + 0.05) in Q5.16: 20 * L + 65536
  localparam logic [SCALED_W-1:0] FLARE_OFFSET = SCALED_W'(65536);

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  typedef struct packed {
    logic [LUM_W-1:0] first;
    logic [LUM_W-1:0] second;
  } lum_pair_t;

  function automatic logic [63:0] mul_q30(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> 30;
  endfunction

  // Power segment of the sRGB curve: y^2.4 = y^2 * y^(2/5), with the
  // fifth root found by a bitwise search. Elaboration only.
  function automatic logic [63:0] pow_entry(input logic [63:0] y);
    logic [63:0] y2;
    logic [63:0] root;
    logic [63:0] cand;
    logic [63:0] p2;
    logic [63:0] p4;
    logic [63:0] p5;
    logic [63:0] v;
    y2   = mul_q30(y, y);
    root = 64'd0;
    for (int bit_idx = 30; bit_idx >= 0; bit_idx--) begin
      cand = root | (64'd1 << bit_idx);
      if (cand <= ONE_Q30) begin
        p2 = mul_q30(cand, cand);
        p4 = mul_q30(p2, p2);
        p5 = mul_q30(p4, cand);
        if (p5 <= y2) begin
          root = cand;
        end
      end
    end
    v = mul_q30(y2, root);
    return (v + 64'd8192) >> 14;
  endfunction

endpackage

// ----- sv/ccr_in_if.sv -----
// ----------------------------------------------------------------------------
// ccr_in_if
// Request channel carrying one pair of sRGB colours.
// ----------------------------------------------------------------------------
interface ccr_in_if #(
  parameter int CHANNEL_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] first_red;
  logic [CHANNEL_BITS-1:0] first_green;
  logic [CHANNEL_BITS-1:0] first_blue;
  logic [CHANNEL_BITS-1:0] second_red;
  logic [CHANNEL_BITS-1:0] second_green;
  logic [CHANNEL_BITS-1:0] second_blue;

  modport source (
    output valid, first_red, first_green, first_blue,
           second_red, second_green, second_blue,
    input  ready
  );

  modport sink (
    input  valid, first_red, first_green, first_blue,
           second_red, second_green, second_blue,
    output ready
  );
endinterface

// ----- sv/ccr_out_if.sv -----
// ----------------------------------------------------------------------------
// ccr_out_if
// Result channel carrying both luminances and the contrast ratio.
// ----------------------------------------------------------------------------
interface ccr_out_if #(
  parameter int RATIO_FRACTION_BITS = 12
);
  import ccr_pkg::*;

  logic                                    valid;
  logic                                    ready;
  logic [LUM_W-1:0]                        first_luminance;
  logic [LUM_W-1:0]                        second_luminance;
  logic [RATIO_INT_BITS+RATIO_FRACTION_BITS-1:0] contrast_value;

  modport source (
    output valid, first_luminance, second_luminance, contrast_value,
    input  ready
  );

  modport sink (
    input  valid, first_luminance, second_luminance, contrast_value,
    output ready
  );
endinterface

// ----- sv/color_contrast_ratio.sv -----
// ----------------------------------------------------------------------------
// color_contrast_ratio
// Relative luminance of two sRGB colours and their contrast ratio.
// ----------------------------------------------------------------------------
// Takes one colour pair per cycle, unless the pipeline is full and the
// output is stalled, and returns one result per request, in order. The
// stages are the linearisation table, the weighted sums, the divide-by-10000
// reciprocal multiply, ordering and scaling, then one stage per quotient bit
// of the restoring divider, which sets the latency.
// Each stage has its own valid bit and a stage loads whenever it is empty or
// the one after it moves, so bubbles close up while the output is stalled.
// Luminances are unsigned Q1.16; contrast is unsigned Q5.RATIO_FRACTION_BITS,
// truncated.
// ----------------------------------------------------------------------------
module color_contrast_ratio #(
  parameter int CHANNEL_BITS        = 8,
  parameter int RATIO_FRACTION_BITS = 12
) (
  input  logic      clk,
  input  logic      rst_n,
  ccr_in_if.sink    in_ch,
  ccr_out_if.source out_ch
);
  import ccr_pkg::*;

  localparam int unsigned TABLE_SIZE = 1 << CHANNEL_BITS;
  localparam int unsigned CODE_MAX   = TABLE_SIZE - 1;
  localparam int unsigned Q_BITS     = RATIO_INT_BITS + RATIO_FRACTION_BITS;
  localparam int unsigned PRE_STAGES = 4;
  localparam int unsigned STAGES     = PRE_STAGES + Q_BITS;
  localparam int unsigned LAST       = STAGES - 1;

  localparam logic [Q_BITS-1:0] RATIO_ONE = Q_BITS'(1) << RATIO_FRACTION_BITS;
  localparam logic [Q_BITS-1:0] RATIO_MAX = Q_BITS'(21) << RATIO_FRACTION_BITS;

  function automatic logic [SUM_W-1:0] weigh(input logic [LUM_W-1:0] r,
                                             input logic [LUM_W-1:0] g,
                                             input logic [LUM_W-1:0] b);
    return SUM_W'(WEIGHT_R) * SUM_W'(r) + SUM_W'(WEIGHT_G) * SUM_W'(g)
         + SUM_W'(WEIGHT_B) * SUM_W'(b);
  endfunction

  function automatic logic [SCALED_W-1:0] flare(input logic [LUM_W-1:0] lum);
    return (SCALED_W'(lum) << 4) + (SCALED_W'(lum) << 2) + FLARE_OFFSET;
  endfunction

  // --------------------------------------------------------------------------
  // Linearisation table
  // --------------------------------------------------------------------------
  logic [LUM_W-1:0] lin_rom [TABLE_SIZE];

  for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_rom
    localparam logic [63:0] CODE    = 64'(gi);
    localparam logic [63:0] CMAX    = 64'(CODE_MAX);
    localparam bit          IS_LIN  = (CODE * 64'd100000) <= (64'd3928 * CMAX);
    localparam logic [63:0] LIN_DEN = 64'd1293 * CMAX;
    localparam logic [63:0] LIN_VAL = (CODE * 64'd6553600 + LIN_DEN / 64'd2) / LIN_DEN;
    localparam logic [63:0] Y_Q30   =
      ((CODE * 64'd1000 + 64'd55 * CMAX) << 30) / (64'd1055 * CMAX);
    localparam logic [63:0] POW_VAL = pow_entry(Y_Q30);
    assign lin_rom[gi] = IS_LIN ? LIN_VAL[LUM_W-1:0] : POW_VAL[LUM_W-1:0];
  end

  // --------------------------------------------------------------------------
  // Stage control
  // --------------------------------------------------------------------------
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;
  logic [STAGES-1:0] go;

  assign go[LAST] = !vld_r[LAST] || out_ch.ready;
  for (genvar gk = 0; gk < LAST; gk++) begin : g_go
    assign go[gk] = !vld_r[gk] || go[gk+1];
  end

  assign vld_nxt = (go & {vld_r[LAST-1:0], in_ch.valid}) | (~go & vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready = go[0];

  // --------------------------------------------------------------------------
  // Table read, weighted sums, divide by 10000, order and scale
  // --------------------------------------------------------------------------
  logic [LUM_W-1:0]    s1_lin_r [6];
  logic [SUM_W-1:0]    s2_sum_r [2];
  logic [PROD_W-1:0]   prod_first;
  logic [PROD_W-1:0]   prod_second;
  lum_pair_t           s3_lum_r;
  lum_pair_t           s4_lum_r;
  logic [SCALED_W-1:0] s4_num_r;
  logic [SCALED_W-1:0] s4_den_r;
  logic                first_lighter;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      s1_lin_r[0] <= lin_rom[in_ch.first_red];
      s1_lin_r[1] <= lin_rom[in_ch.first_green];
      s1_lin_r[2] <= lin_rom[in_ch.first_blue];
      s1_lin_r[3] <= lin_rom[in_ch.second_red];
      s1_lin_r[4] <= lin_rom[in_ch.second_green];
      s1_lin_r[5] <= lin_rom[in_ch.second_blue];
    end
  end

  always_ff @(posedge clk) begin
    if (go[1]) begin
      s2_sum_r[0] <= weigh(s1_lin_r[0], s1_lin_r[1], s1_lin_r[2]);
      s2_sum_r[1] <= weigh(s1_lin_r[3], s1_lin_r[4], s1_lin_r[5]);
    end
  end

  assign prod_first  = PROD_W'(s2_sum_r[0]) * PROD_W'(RECIP_10000);
  assign prod_second = PROD_W'(s2_sum_r[1]) * PROD_W'(RECIP_10000);

  always_ff @(posedge clk) begin
    if (go[2]) begin
      s3_lum_r.first  <= prod_first[RECIP_SHIFT +: LUM_W];
      s3_lum_r.second <= prod_second[RECIP_SHIFT +: LUM_W];
    end
  end

  assign first_lighter = s3_lum_r.first > s3_lum_r.second;

  always_ff @(posedge clk) begin
    if (go[3]) begin
      s4_lum_r <= s3_lum_r;
      s4_num_r <= flare(first_lighter ? s3_lum_r.first : s3_lum_r.second);
      s4_den_r <= flare(first_lighter ? s3_lum_r.second : s3_lum_r.first);
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider, one quotient bit per stage. The low register holds
  // the dividend bits still to come and collects the quotient behind them.
  // --------------------------------------------------------------------------
  logic [SCALED_W-1:0] div_rem_r [Q_BITS];
  logic [Q_BITS-1:0]   div_lq_r  [Q_BITS];
  logic [SCALED_W-1:0] div_den_r [Q_BITS];
  lum_pair_t           div_lum_r [Q_BITS];

  for (genvar gj = 0; gj < Q_BITS; gj++) begin : g_div
    logic [SCALED_W-1:0] rem_in;
    logic [Q_BITS-1:0]   lq_in;
    logic [SCALED_W-1:0] den_in;
    lum_pair_t           lum_in;
    logic [SCALED_W:0]   trial;
    logic [SCALED_W:0]   diff;
    logic                fits;

    if (gj == 0) begin : g_head
      assign rem_in = s4_num_r >> RATIO_INT_BITS;
      assign lq_in  = {s4_num_r[RATIO_INT_BITS-1:0], {RATIO_FRACTION_BITS{1'b0}}};
      assign den_in = s4_den_r;
      assign lum_in = s4_lum_r;
    end else begin : g_body
      assign rem_in = div_rem_r[gj-1];
      assign lq_in  = div_lq_r[gj-1];
      assign den_in = div_den_r[gj-1];
      assign lum_in = div_lum_r[gj-1];
    end

    assign trial = {rem_in, lq_in[Q_BITS-1]};
    assign diff  = trial - {1'b0, den_in};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (go[PRE_STAGES+gj]) begin
        div_rem_r[gj] <= fits ? diff[SCALED_W-1:0] : trial[SCALED_W-1:0];
        div_lq_r[gj]  <= {lq_in[Q_BITS-2:0], fits};
        div_den_r[gj] <= den_in;
        div_lum_r[gj] <= lum_in;
      end
    end
  end

  assign out_ch.valid            = vld_r[LAST];
  assign out_ch.first_luminance  = div_lum_r[Q_BITS-1].first;
  assign out_ch.second_luminance = div_lum_r[Q_BITS-1].second;
  assign out_ch.contrast_value   = div_lq_r[Q_BITS-1];

`ifndef SYNTHESIS
  a_lum_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (s3_lum_r.first <= LUM_ONE) && (s3_lum_r.second <= LUM_ONE))
    else $error("luminance above 1.0");

  a_div_order: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> s4_den_r <= s4_num_r)
    else $error("divisor larger than dividend");

  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.contrast_value >= RATIO_ONE)
                     && (out_ch.contrast_value <= RATIO_MAX))
    else $error("contrast outside 1..21");

  a_equal_unity: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.first_luminance == out_ch.second_luminance)
    |-> out_ch.contrast_value == RATIO_ONE)
    else $error("equal luminances without unity contrast");
`endif

endmodule
